>>> rtl/blm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and constants for the bracket language machine: transaction
// commands, result status codes, instruction codes and the symbol decoder.
// ----------------------------------------------------------------------------
package blm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_STEP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_EXEC    = 3'd1,
    ST_HALTED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_BRACKET = 3'd4,
    ST_RESET   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    INS_RIGHT = 4'd0,
    INS_LEFT  = 4'd1,
    INS_INC   = 4'd2,
    INS_DEC   = 4'd3,
    INS_OUT   = 4'd4,
    INS_IN    = 4'd5,
    INS_OPEN  = 4'd6,
    INS_CLOSE = 4'd7,
    INS_NOP   = 4'd8
  } instr_e;

  // Control flags produced by the step unit
  typedef struct packed {
    logic cell_we;
    logic char_valid;
  } step_ctl_t;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  function automatic instr_e decode_symbol(input logic [7:0] sym);
    instr_e code;
    unique case (sym)
      CH_RIGHT: code = INS_RIGHT;
      CH_LEFT:  code = INS_LEFT;
      CH_INC:   code = INS_INC;
      CH_DEC:   code = INS_DEC;
      CH_OUT:   code = INS_OUT;
      CH_IN:    code = INS_IN;
      CH_OPEN:  code = INS_OPEN;
      CH_CLOSE: code = INS_CLOSE;
      default:  code = INS_NOP;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bracket_language_machine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_language_machine
// Item-driven interpreter for the eight-command bracket language: clear, load
// one program character, restart, or execute one instruction.
// ----------------------------------------------------------------------------
// Each transaction has an accept cycle and a work cycle: the accept cycle issues
// the reads of the program, partner, bracket stack and tape memories at the
// current counters, and the work cycle computes the outcome, writes back and
// loads the result register. The work cycle waits while a previous result is
// still held by out_stall_i. After reset and after every clear transaction the
// tape is zeroed by a sweep, one cell a cycle, during which in_stall_o stays
// high. Brackets are paired at load time; a step is refused with a bracket
// error while any bracket is unmatched.
module bracket_language_machine
  import blm_pkg::*;
#(
  parameter int CODE_DEPTH = 1024,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        char_valid_o,
  output logic [7:0]  out_char_o,
  output logic [10:0] program_counter_o,
  output logic [9:0]  data_position_o
);

  localparam int CA = $clog2(CODE_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH + 1);
  localparam int TA = $clog2(TAPE_DEPTH);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_WORK
  } state_e;

  // Control state
  state_e        state_q, state_d;
  logic [CW-1:0] pc_q, pc_d;
  logic [TA-1:0] ptr_q, ptr_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] depth_q, depth_d;
  logic          fault_q, fault_d;
  logic [TA-1:0] sweep_q, sweep_d;
  logic          out_valid_q, out_valid_d;

  // Result payload
  status_e       stat_q, stat_d;
  logic          chv_q, chv_d;
  logic [7:0]    char_q, char_d;
  logic [10:0]   po_q, po_d;
  logic [9:0]    dp_q, dp_d;

  // Transaction payload and registered memory reads
  cmd_e                 op_q;
  logic [7:0]           sym_q;
  instr_e               prog_rd_q;
  logic [CA-1:0]        open_rd_q;
  logic [CA-1:0]        close_rd_q;
  logic [CA-1:0]        stack_rd_q;
  logic [CELL_BITS-1:0] tape_rd_q;

  // Memories
  instr_e               prog_mem  [CODE_DEPTH];
  logic [CA-1:0]        open_mem  [CODE_DEPTH];
  logic [CA-1:0]        close_mem [CODE_DEPTH];
  logic [CA-1:0]        stack_mem [CODE_DEPTH];
  logic [CELL_BITS-1:0] tape_mem  [TAPE_DEPTH];

  logic                 in_acc;
  logic                 out_free;
  logic [CW-1:0]        depth_m1;
  logic                 prog_we;
  logic                 stack_we;
  logic                 pair_we;
  logic                 tape_we;
  logic [TA-1:0]        tape_waddr;
  logic [CELL_BITS-1:0] tape_wdata;
  instr_e               sym_code;
  logic [CW+10:0]       pc_ext;
  logic [TA+9:0]        ptr_ext;

  step_ctl_t            step_ctl;
  logic [CELL_BITS-1:0] step_cell;
  logic [TA-1:0]        step_ptr;
  logic [CW-1:0]        step_pc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign depth_m1   = depth_q - CW'(1);
  assign sym_code   = decode_symbol(sym_q);

  blm_step #(
    .CODE_DEPTH (CODE_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .CELL_BITS  (CELL_BITS)
  ) u_step (
    .instr_i         (prog_rd_q),
    .cell_i          (tape_rd_q),
    .ptr_i           (ptr_q),
    .pc_i            (pc_q),
    .open_partner_i  (open_rd_q),
    .close_partner_i (close_rd_q),
    .ctl_o           (step_ctl),
    .cell_o          (step_cell),
    .ptr_o           (step_ptr),
    .pc_o            (step_pc)
  );

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    ptr_d       = ptr_q;
    len_d       = len_q;
    depth_d     = depth_q;
    fault_d     = fault_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && out_stall_i;
    stat_d      = stat_q;
    chv_d       = chv_q;
    char_d      = char_q;
    po_d        = po_q;
    dp_d        = dp_q;
    prog_we     = 1'b0;
    stack_we    = 1'b0;
    pair_we     = 1'b0;
    tape_we     = 1'b0;
    tape_waddr  = ptr_q;
    tape_wdata  = step_cell;

    unique case (state_q)
      S_SWEEP: begin
        tape_we    = 1'b1;
        tape_waddr = sweep_q;
        tape_wdata = '0;
        sweep_d    = sweep_q + TA'(1);
        if (sweep_q == TA'(TAPE_DEPTH - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) state_d = S_WORK;
      end
      S_WORK: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          chv_d       = 1'b0;
          char_d      = '0;
          unique case (op_q)
            CMD_CLEAR: begin
              len_d   = '0;
              depth_d = '0;
              pc_d    = '0;
              ptr_d   = '0;
              fault_d = 1'b0;
              stat_d  = ST_RESET;
              state_d = S_SWEEP;
            end
            CMD_LOAD: begin
              if (len_q == CW'(CODE_DEPTH)) begin
                stat_d = ST_FULL;
              end else begin
                prog_we = 1'b1;
                len_d   = len_q + CW'(1);
                stat_d  = ST_LOADED;
                if (sym_code == INS_OPEN) begin
                  stack_we = 1'b1;
                  depth_d  = depth_q + CW'(1);
                end else if (sym_code == INS_CLOSE) begin
                  if (depth_q == '0) begin
                    fault_d = 1'b1;
                    stat_d  = ST_BRACKET;
                  end else begin
                    pair_we = 1'b1;
                    depth_d = depth_m1;
                  end
                end
              end
            end
            CMD_RESTART: begin
              pc_d   = '0;
              stat_d = ST_RESET;
            end
            CMD_STEP: begin
              priority if (fault_q || depth_q != '0) begin
                stat_d = ST_BRACKET;
              end else if (pc_q >= len_q) begin
                stat_d = ST_HALTED;
              end else begin
                stat_d  = ST_EXEC;
                pc_d    = step_pc;
                ptr_d   = step_ptr;
                tape_we = step_ctl.cell_we;
                chv_d   = step_ctl.char_valid;
                char_d  = step_ctl.char_valid ? tape_rd_q[7:0] : 8'h00;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    pc_ext  = {11'b0, pc_d};
    ptr_ext = {10'b0, ptr_d};
    if (state_q == S_WORK && out_free) begin
      po_d = pc_ext[10:0];
      dp_d = ptr_ext[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      pc_q        <= '0;
      ptr_q       <= '0;
      len_q       <= '0;
      depth_q     <= '0;
      fault_q     <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ptr_q       <= ptr_d;
      len_q       <= len_d;
      depth_q     <= depth_d;
      fault_q     <= fault_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    chv_q  <= chv_d;
    char_q <= char_d;
    po_q   <= po_d;
    dp_q   <= dp_d;
    if (in_acc) begin
      op_q  <= cmd_e'(opcode_i);
      sym_q <= symbol_i;
    end
  end

  // Reads are issued at accept time against the committed counters
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prog_rd_q  <= prog_mem[pc_q[CA-1:0]];
      open_rd_q  <= open_mem[pc_q[CA-1:0]];
      close_rd_q <= close_mem[pc_q[CA-1:0]];
      stack_rd_q <= stack_mem[depth_m1[CA-1:0]];
      tape_rd_q  <= tape_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[len_q[CA-1:0]] <= sym_code;
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[depth_q[CA-1:0]] <= len_q[CA-1:0];
  end

  // Open bracket learns its close partner when the close bracket loads
  always_ff @(posedge clk_i) begin
    if (pair_we) open_mem[stack_rd_q] <= len_q[CA-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) close_mem[len_q[CA-1:0]] <= stack_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = stat_q;
  assign char_valid_o      = chv_q;
  assign out_char_o        = char_q;
  assign program_counter_o = po_q;
  assign data_position_o   = dp_q;

  a_accept_to_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_WORK)
    else $error("accepted transaction did not enter the work cycle");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(CODE_DEPTH))
    else $error("program length beyond program store depth");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= len_q)
    else $error("open bracket count exceeds program length");

  a_char_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> status_o == ST_EXEC)
    else $error("character flagged on a result that is not an executed step");

endmodule
`default_nettype wire

>>> rtl/blm_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blm_step
// Executes one instruction: next data pointer, next program counter, new cell
// value and the output/write flags.
// ----------------------------------------------------------------------------
module blm_step
  import blm_pkg::*;
#(
  parameter int CODE_DEPTH = 1024,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_BITS  = 32,
  localparam int CA = $clog2(CODE_DEPTH),
  localparam int CW = $clog2(CODE_DEPTH + 1),
  localparam int TA = $clog2(TAPE_DEPTH)
) (
  input  instr_e               instr_i,
  input  logic [CELL_BITS-1:0] cell_i,
  input  logic [TA-1:0]        ptr_i,
  input  logic [CW-1:0]        pc_i,
  input  logic [CA-1:0]        open_partner_i,
  input  logic [CA-1:0]        close_partner_i,
  output step_ctl_t            ctl_o,
  output logic [CELL_BITS-1:0] cell_o,
  output logic [TA-1:0]        ptr_o,
  output logic [CW-1:0]        pc_o
);

  always_comb begin
    ctl_o  = '0;
    cell_o = cell_i + CELL_BITS'(1);
    ptr_o  = ptr_i;
    pc_o   = pc_i + CW'(1);
    unique case (instr_i)
      INS_RIGHT: begin
        ptr_o = (ptr_i == TA'(TAPE_DEPTH - 1)) ? '0 : ptr_i + TA'(1);
      end
      INS_LEFT: begin
        ptr_o = (ptr_i == '0) ? TA'(TAPE_DEPTH - 1) : ptr_i - TA'(1);
      end
      INS_INC: begin
        ctl_o.cell_we = 1'b1;
      end
      INS_DEC: begin
        ctl_o.cell_we = 1'b1;
        cell_o        = cell_i - CELL_BITS'(1);
      end
      INS_OUT: begin
        ctl_o.char_valid = 1'b1;
      end
      // jump lands just past the partner bracket
      INS_OPEN: begin
        if (cell_i == '0) pc_o = CW'(open_partner_i) + CW'(1);
      end
      INS_CLOSE: begin
        if (cell_i != '0) pc_o = CW'(close_partner_i) + CW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bracket_language_machine. Directed programs cover
// the cell wrap, pointer wrap, output, skip-forward loop, open and unmatched
// brackets. Random balanced programs with steps and restarts follow, mixed
// with noise transactions. Every result is compared field by field against
// an in-bench interpreter.
// ----------------------------------------------------------------------------
module tb;
  import blm_pkg::*;

  localparam int CODE_DEPTH = 1024;
  localparam int TAPE_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 570;
  // a clear sweeps the whole tape with no transaction at all
  localparam int IDLE_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    cmd_e       op;
    logic [7:0] sym;
    bit         drain;
  } cmd_item_t;

  typedef struct packed {
    status_e     status;
    logic        char_valid;
    logic [7:0]  out_char;
    logic [10:0] pc;
    logic [9:0]  pos;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = 2'd0;
  logic [7:0]  symbol_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        char_valid_o;
  logic [7:0]  out_char_o;
  logic [10:0] program_counter_o;
  logic [9:0]  data_position_o;

  bracket_language_machine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .symbol_i          (symbol_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .char_valid_o      (char_valid_o),
    .out_char_o        (out_char_o),
    .program_counter_o (program_counter_o),
    .data_position_o   (data_position_o)
  );

  // Interpreter state
  instr_e      code_mem [CODE_DEPTH];
  logic [9:0]  mate_mem [CODE_DEPTH];
  logic [9:0]  open_stack [CODE_DEPTH];
  logic [31:0] tape [TAPE_DEPTH];
  logic [10:0] code_len;
  logic [10:0] open_depth;
  logic [10:0] pc;
  logic [9:0]  tape_pos;
  bit          bracket_bad;

  cmd_item_t   cmd_backlog [$];
  answer_t     machine_answers [$];

  int unsigned gen_len;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  logic        in_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned chars_seen = 0;
  int unsigned status_hits [8];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void wipe_machine();
    for (int i = 0; i < TAPE_DEPTH; i++) tape[i] = '0;
    code_len    = '0;
    open_depth  = '0;
    pc          = '0;
    tape_pos    = '0;
    bracket_bad = 1'b0;
  endfunction

  function automatic instr_e char_to_instr(logic [7:0] c);
    instr_e ins;
    case (c)
      CH_RIGHT: ins = INS_RIGHT;
      CH_LEFT:  ins = INS_LEFT;
      CH_INC:   ins = INS_INC;
      CH_DEC:   ins = INS_DEC;
      CH_OUT:   ins = INS_OUT;
      CH_IN:    ins = INS_IN;
      CH_OPEN:  ins = INS_OPEN;
      CH_CLOSE: ins = INS_CLOSE;
      default:  ins = INS_NOP;
    endcase
    return ins;
  endfunction

  function automatic answer_t interpret_item(cmd_e op, logic [7:0] sym);
    answer_t     r;
    instr_e      ins;
    logic [31:0] cell_val;
    logic [10:0] nxt;
    logic [9:0]  at;
    logic [9:0]  mate;
    r = '0;
    r.status = ST_EXEC;
    case (op)
      CMD_CLEAR: begin
        wipe_machine();
        r.status = ST_RESET;
      end
      CMD_LOAD: begin
        if (code_len == 11'(CODE_DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          at = code_len[9:0];
          ins = char_to_instr(sym);
          code_mem[at] = ins;
          code_len = code_len + 11'd1;
          r.status = ST_LOADED;
          if (ins == INS_OPEN) begin
            open_stack[open_depth[9:0]] = at;
            open_depth = open_depth + 11'd1;
          end else if (ins == INS_CLOSE) begin
            if (open_depth == 0) begin
              bracket_bad = 1'b1;
              mate_mem[at] = '0;
              r.status = ST_BRACKET;
            end else begin
              open_depth = open_depth - 11'd1;
              mate = open_stack[open_depth[9:0]];
              mate_mem[at] = mate;
              mate_mem[mate] = at;
            end
          end
        end
      end
      CMD_RESTART: begin
        pc = '0;
        r.status = ST_RESET;
      end
      default: begin
        if (bracket_bad || open_depth != 0) begin
          r.status = ST_BRACKET;
        end else if (pc >= code_len) begin
          r.status = ST_HALTED;
        end else begin
          cell_val = tape[tape_pos];
          nxt = pc + 11'd1;
          case (code_mem[pc[9:0]])
            INS_RIGHT: tape_pos = tape_pos + 10'd1;
            INS_LEFT:  tape_pos = tape_pos - 10'd1;
            INS_INC:   tape[tape_pos] = cell_val + 32'd1;
            INS_DEC:   tape[tape_pos] = cell_val - 32'd1;
            INS_OUT: begin
              r.char_valid = 1'b1;
              r.out_char = cell_val[7:0];
            end
            INS_OPEN:  if (cell_val == 0) nxt = {1'b0, mate_mem[pc[9:0]]} + 11'd1;
            INS_CLOSE: if (cell_val != 0) nxt = {1'b0, mate_mem[pc[9:0]]} + 11'd1;
            default: ;
          endcase
          pc = nxt;
        end
      end
    endcase
    r.pc = pc;
    r.pos = tape_pos;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  function automatic void push_item(cmd_e op, logic [7:0] sym, bit drain);
    cmd_item_t it;
    it.op = op;
    it.sym = sym;
    it.drain = drain;
    cmd_backlog.insert(cmd_backlog.size(), it);
    if (op == CMD_CLEAR) gen_len = 0;
    else if (op == CMD_LOAD) gen_len++;
  endfunction

  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(CMD_LOAD, s[i], 1'b0);
  endfunction

  // no brackets; cells drift around zero so loops tend to terminate
  function automatic logic [7:0] body_char();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 15);
    if (pick < 4) c = CH_INC;
    else if (pick < 7) c = CH_DEC;
    else if (pick < 9) c = CH_RIGHT;
    else if (pick < 11) c = CH_LEFT;
    else if (pick < 13) c = CH_OUT;
    else if (pick < 14) c = CH_IN;
    else c = 8'($urandom_range(0, 255));
    if (c == CH_OPEN || c == CH_CLOSE) c = 8'h20;
    return c;
  endfunction

  function automatic void push_program(int unsigned n, bit drain);
    int unsigned depth;
    int unsigned pick;
    logic [7:0]  c;
    depth = 0;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0 && depth < 4) begin
        c = CH_OPEN;
        depth++;
      end else if (pick == 1 && depth > 0) begin
        c = CH_CLOSE;
        depth--;
      end else begin
        c = body_char();
      end
      push_item(CMD_LOAD, c, drain && i == 0);
    end
    for (; depth > 0; depth--) push_item(CMD_LOAD, CH_CLOSE, 1'b0);
  endfunction

  function automatic void push_steps(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_item(CMD_STEP, 8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ------------------------------------------------------------------------
  // Driver: one transaction held until accepted, then a random gap
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (!rst_ni || (in_valid_i && !in_taken)) begin
      // hold
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (cmd_backlog.size() != 0 &&
                 (!cmd_backlog[0].drain || machine_answers.size() == 0)) begin
      in_valid_i <= 1'b1;
      opcode_i <= cmd_backlog[0].op;
      symbol_i <= cmd_backlog[0].sym;
      void'(cmd_backlog.pop_front());
      gap_left <= pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  // ------------------------------------------------------------------------
  // Checking
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h (result %0d)",
                                name, got, want, results_seen));
  endtask

  always @(posedge clk_i) begin : scoreboard_p
    answer_t want;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (machine_answers.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = machine_answers.pop_front();
          check_field("status", 32'(status_o), 32'(want.status));
          check_field("char_valid", 32'(char_valid_o), 32'(want.char_valid));
          check_field("out_char", 32'(out_char_o), 32'(want.out_char));
          check_field("program_counter", 32'(program_counter_o), 32'(want.pc));
          check_field("data_position", 32'(data_position_o), 32'(want.pos));
          status_hits[want.status]++;
          if (want.char_valid) chars_seen++;
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        machine_answers.insert(machine_answers.size(),
                               interpret_item(cmd_e'(opcode_i), symbol_i));
        items_sent++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus and end of run
  initial begin
    int unsigned base;
    int unsigned kind;
    int unsigned n;
    bit          hold;
    bit          first;
    wipe_machine();
    gen_len = 0;
    #14 rst_ni = 1'b1;

    // cell wrap below zero, pointer wrap, output, input no-op, other byte,
    // forward skip over an empty loop, then past the end
    load_text("+--.<.>>,");
    push_item(CMD_LOAD, 8'hFF, 1'b0);
    load_text("[]");
    push_item(CMD_RESTART, 8'h00, 1'b0);
    push_steps(13);
    // open bracket pending, matched, then an unmatched close
    push_item(CMD_LOAD, CH_OPEN, 1'b0);
    push_item(CMD_STEP, 8'hA5, 1'b0);
    push_item(CMD_LOAD, CH_CLOSE, 1'b0);
    push_item(CMD_LOAD, CH_CLOSE, 1'b0);
    push_item(CMD_STEP, 8'h5A, 1'b0);
    push_item(CMD_CLEAR, 8'hFF, 1'b0);

    base = cmd_backlog.size();
    first = 1'b1;
    while (cmd_backlog.size() < base + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      hold = first || ($urandom_range(0, 9) == 0);
      first = 1'b0;
      if (kind < 6 || gen_len > 900) begin
        push_item(CMD_CLEAR, 8'($urandom_range(0, 255)), hold);
      end else if (kind < 76) begin
        if (gen_len > 120 && $urandom_range(0, 1) == 1)
          push_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
        n = $urandom_range(3, 24);
        push_program(n, hold);
        if ($urandom_range(0, 4) != 0)
          push_item(CMD_RESTART, 8'($urandom_range(0, 255)), 1'b0);
        push_steps($urandom_range(1, 3 * n + 8));
      end else if (kind < 88) begin
        if ($urandom_range(0, 1) == 1)
          push_item(CMD_RESTART, 8'($urandom_range(0, 255)), hold);
        push_steps($urandom_range(1, 20));
      end else begin
        n = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n; i++)
          push_item(cmd_e'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                    hold && i == 0);
        if ($urandom_range(0, 1) == 1)
          push_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
      end
    end

    while (cmd_backlog.size() != 0 || in_valid_i || machine_answers.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (machine_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", machine_answers.size()));

    $display("%0d transactions sent, %0d results checked, %0d characters emitted",
             items_sent, results_seen, chars_seen);
    $display("status mix: loaded %0d exec %0d halted %0d full %0d bracket %0d reset %0d",
             status_hits[ST_LOADED], status_hits[ST_EXEC], status_hits[ST_HALTED],
             status_hits[ST_FULL], status_hits[ST_BRACKET], status_hits[ST_RESET]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
